FILE: src/multi_waveform_phase_oscillator_unit_defines.svh
// Assertion macros used by the oscillator's checker file.
`ifndef MULTI_WAVEFORM_PHASE_OSCILLATOR_UNIT_DEFINES_SVH
`define MULTI_WAVEFORM_PHASE_OSCILLATOR_UNIT_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define MWPO_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define MWPO_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

FILE: src/mwpo_pkg.sv
// Package with the types and constants of the multi-waveform phase oscillator.
package mwpo_pkg;

   localparam int FREQ_WIDTH      = 24;
   localparam int SAMPLE_WIDTH    = 16;
   localparam int SCALE_WIDTH     = 32;
   localparam int PHASE_WIDTH     = 32;
   localparam int INC_WIDTH       = 29;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int WAVE_WIDTH      = 4;

   typedef enum logic [WAVE_WIDTH-1:0] {
      WAVE_SINE     = 4'd0,
      WAVE_COSINE   = 4'd1,
      WAVE_SAW      = 4'd2,
      WAVE_TRIANGLE = 4'd3,
      WAVE_SQUARE   = 4'd4,
      WAVE_NOISE    = 4'd5,
      WAVE_IMPULSE  = 4'd6,
      WAVE_PHASOR   = 4'd7,
      WAVE_RECT     = 4'd8
   } wave_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WAVE_SELECT = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_SCALE  = 4'd1;

   localparam wave_type               WAVE_SELECT_RESET = WAVE_SINE;
   localparam logic [SCALE_WIDTH-1:0] STEP_SCALE_RESET  = 32'd91625968;
   localparam logic [PHASE_WIDTH-1:0] LFSR_SEED         = 32'h0000_0001;
   localparam logic [PHASE_WIDTH-1:0] LFSR_MASK         = 32'hD000_0001;

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX  = 16'sh7FFF;
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN  = 16'sh8000;
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_ZERO = 16'sh0000;

endpackage

FILE: src/mwpo_if.sv
// Valid/ready channel interfaces for the oscillator's request, response and CSR ports.
interface mwpo_req_if;
   import mwpo_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [FREQ_WIDTH-1:0] frequency;
   modport source (output valid, output frequency, input ready);
   modport sink   (input valid, input frequency, output ready);
endinterface

interface mwpo_rsp_if;
   import mwpo_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface mwpo_csr_if;
   import mwpo_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/multi_waveform_phase_oscillator_unit.sv
// Multi-waveform phase-accumulator oscillator: one sample per frequency transaction.
//
// Every request transaction carries a frequency and returns one Q1.15 sample of the
// waveform chosen by wave_select. The block is a three-stage pipeline: an input
// register, a stage that forms the phase increment with one 24x32 multiply, and a
// stage that advances the shared Q2.30 phase and selects the waveform into the
// response register. A new transaction is taken every cycle while the response
// channel is not stalled; the phase recurrence in the last stage sets that rate.
// Sine and cosine read a quarter-wave table of 2^(SINE_TABLE_BITS-2)+1 constant
// entries; noise comes from a 32-bit Galois LFSR.
// CSR writes are always accepted and should be made only while the pipeline is empty.
module multi_waveform_phase_oscillator_unit #(
   parameter int SINE_TABLE_BITS = 10
) (
   input logic         clock,
   input logic         reset,
   mwpo_req_if.sink    req_chan,
   mwpo_rsp_if.source  rsp_chan,
   mwpo_csr_if.sink    csr_chan
);
   import mwpo_pkg::*;

   localparam int QUARTER_BITS   = SINE_TABLE_BITS - 2;
   localparam int ROM_ADDR_BITS  = SINE_TABLE_BITS - 1;
   localparam int SINE_ROM_DEPTH = (1 << QUARTER_BITS) + 1;
   localparam int PROD_WIDTH     = FREQ_WIDTH + SCALE_WIDTH;

   localparam logic [SINE_TABLE_BITS-1:0] SINE_QUARTER =
      SINE_TABLE_BITS'(1 << QUARTER_BITS);
   localparam logic [ROM_ADDR_BITS-1:0] QUARTER_SPAN =
      ROM_ADDR_BITS'(1 << QUARTER_BITS);

   localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
   localparam logic signed [33:0] TWO_Q30  = 34'sd2147483648;
   localparam logic signed [33:0] HALF_Q30 = 34'sd536870912;
   localparam logic signed [33:0] QTR_Q30  = 34'sd268435456;

   localparam longint unsigned POLY_A = 51472;
   localparam longint unsigned POLY_B = 21167;
   localparam longint unsigned POLY_C = 2611;

   // Magnitude of the sine at offset m of a quarter wave, in Q15.
   function automatic logic [SAMPLE_WIDTH-1:0] sine_entry(input int unsigned m);
      longint unsigned z;
      longint unsigned z2;
      longint unsigned t;
      longint unsigned y;
      z  = longint'(m) << (17 - SINE_TABLE_BITS);
      z2 = (z * z) >> 15;
      t  = POLY_B - ((z2 * POLY_C) >> 15);
      t  = POLY_A - ((z2 * t) >> 15);
      y  = (z * t) >> 15;
      if (y > 64'd32767) begin
         y = 64'd32767;
      end
      return SAMPLE_WIDTH'(y);
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat16(input logic signed [33:0] v);
      logic signed [SAMPLE_WIDTH-1:0] r;
      if (v > 34'sd32767) begin
         r = SAMPLE_MAX;
      end else if (v < -34'sd32768) begin
         r = SAMPLE_MIN;
      end else begin
         r = v[SAMPLE_WIDTH-1:0];
      end
      return r;
   endfunction

   logic [SAMPLE_WIDTH-1:0] sine_rom [SINE_ROM_DEPTH];

   for (genvar k = 0; k < SINE_ROM_DEPTH; k++) begin : g_sine_rom
      assign sine_rom[k] = sine_entry(k);
   end

   // Control and configuration registers.
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s2_valid_ff, s2_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   wave_type               wave_ff, wave_in;
   logic [SCALE_WIDTH-1:0] scale_ff, scale_in;
   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [PHASE_WIDTH-1:0] lfsr_ff, lfsr_in;

   // Payload registers.
   logic [FREQ_WIDTH-1:0]          freq_ff;
   logic [INC_WIDTH-1:0]           inc_ff, inc_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;

   logic ready1, ready2, ready3;
   logic load1, load2, load3;

   logic [PROD_WIDTH-1:0] prod;

   logic signed [33:0] p, p_wrap, p_step, p_new, q, tri_x, inc_ext;
   logic [SINE_TABLE_BITS-1:0]     sine_idx;
   logic [1:0]                     sine_quad;
   logic [ROM_ADDR_BITS-1:0]       sine_addr;
   logic signed [SAMPLE_WIDTH-1:0] sine_val;
   logic [PHASE_WIDTH-1:0]         lfsr_next;
   logic                           keep_phase;

   // Each stage frees up when it is empty or when it hands its transaction onward.
   assign ready3 = !rsp_valid_ff || rsp_chan.ready;
   assign load3  = s2_valid_ff && ready3;
   assign ready2 = !s2_valid_ff || ready3;
   assign load2  = s1_valid_ff && ready2;
   assign ready1 = !s1_valid_ff || ready2;
   assign load1  = req_chan.valid && ready1;

   assign req_chan.ready = ready1;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.sample = sample_ff;

   assign s1_valid_in  = load1 || (s1_valid_ff && !load2);
   assign s2_valid_in  = load2 || (s2_valid_ff && !load3);
   assign rsp_valid_in = load3 || (rsp_valid_ff && !rsp_chan.ready);

   always_comb begin
      wave_in  = wave_ff;
      scale_in = scale_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_WAVE_SELECT: wave_in  = wave_type'(csr_chan.data[WAVE_WIDTH-1:0]);
            CSR_STEP_SCALE:  scale_in = csr_chan.data[SCALE_WIDTH-1:0];
            default:         ;
         endcase
      end
   end

   // Increment stage; anything at or above half a cycle saturates just below it.
   assign prod = PROD_WIDTH'(freq_ff) * PROD_WIDTH'(scale_ff);

   always_comb begin
      if (|prod[PROD_WIDTH-1:INC_WIDTH+16]) begin
         inc_in = '1;
      end else begin
         inc_in = prod[INC_WIDTH+15:16];
      end
   end

   // Phase and waveform stage.
   always_comb begin
      p       = $signed({{2{phase_ff[PHASE_WIDTH-1]}}, phase_ff});
      inc_ext = $signed({5'b0, inc_ff});
      p_wrap  = (p >= ONE_Q30) ? p - ONE_Q30 : p;
      p_step  = p_wrap + inc_ext;
      q       = p_step;
      tri_x   = (q <= HALF_Q30) ? q - QTR_Q30 : ONE_Q30 - q - QTR_Q30;

      sine_idx  = phase_ff[29 -: SINE_TABLE_BITS] +
                  ((wave_ff == WAVE_COSINE) ? SINE_QUARTER : '0);
      sine_quad = sine_idx[SINE_TABLE_BITS-1 -: 2];
      if (sine_quad[0]) begin
         sine_addr = QUARTER_SPAN - {1'b0, sine_idx[QUARTER_BITS-1:0]};
      end else begin
         sine_addr = {1'b0, sine_idx[QUARTER_BITS-1:0]};
      end
      sine_val = sine_quad[1] ? -$signed(sine_rom[sine_addr]) : $signed(sine_rom[sine_addr]);

      lfsr_next = {1'b0, lfsr_ff[PHASE_WIDTH-1:1]} ^ (lfsr_ff[0] ? LFSR_MASK : '0);

      p_new      = p_step;
      keep_phase = 1'b0;
      lfsr_in    = lfsr_ff;
      case (wave_ff)
         WAVE_SINE, WAVE_COSINE: begin
            sample_in = sine_val;
         end
         WAVE_SAW: begin
            // The saw steps the phase by twice the increment, so it folds by 2.0.
            sample_in = sat16(p >>> 15);
            p_new     = ((p >= ONE_Q30) ? p - TWO_Q30 : p) + (inc_ext <<< 1);
         end
         WAVE_TRIANGLE: begin
            sample_in = sat16(tri_x >>> 13);
         end
         WAVE_SQUARE: begin
            if (p < HALF_Q30) begin
               sample_in = SAMPLE_MIN;
            end else if (p > HALF_Q30) begin
               sample_in = SAMPLE_MAX;
            end else begin
               sample_in = SAMPLE_ZERO;
            end
         end
         WAVE_NOISE: begin
            sample_in  = $signed(lfsr_next[PHASE_WIDTH-1 -: SAMPLE_WIDTH]);
            keep_phase = 1'b1;
            if (load3) begin
               lfsr_in = lfsr_next;
            end
         end
         WAVE_IMPULSE: begin
            sample_in = (p_wrap < inc_ext) ? SAMPLE_MAX : SAMPLE_ZERO;
         end
         WAVE_PHASOR: begin
            sample_in = sat16(p >>> 15);
         end
         WAVE_RECT: begin
            sample_in  = SAMPLE_MAX;
            keep_phase = 1'b1;
         end
         default: begin
            sample_in  = SAMPLE_ZERO;
            keep_phase = 1'b1;
         end
      endcase

      phase_in = (load3 && !keep_phase) ? p_new[PHASE_WIDTH-1:0] : phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wave_ff      <= WAVE_SELECT_RESET;
         scale_ff     <= STEP_SCALE_RESET;
         phase_ff     <= '0;
         lfsr_ff      <= LFSR_SEED;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         wave_ff      <= wave_in;
         scale_ff     <= scale_in;
         phase_ff     <= phase_in;
         lfsr_ff      <= lfsr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         freq_ff <= req_chan.frequency;
      end
      if (load2) begin
         inc_ff <= inc_in;
      end
      if (load3) begin
         sample_ff <= sample_in;
      end
   end

endmodule

FILE: src/mwpo_checker.sv
// Port-level checker for the oscillator, bound to the top level.
`include "multi_waveform_phase_oscillator_unit_defines.svh"

module mwpo_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_ready,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic signed [mwpo_pkg::SAMPLE_WIDTH-1:0] rsp_sample
);
   import mwpo_pkg::*;

   // A response that is offered stays offered until it is taken.
   `MWPO_ASSERT(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response valid dropped before its transaction completed")

   // A stalled response keeps its sample.
   `MWPO_ASSERT(a_rsp_sample_hold, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_sample), "response sample changed while stalled")

   // A response that appears at an empty output must be preceded by an accepted request.
   `MWPO_ASSERT(a_rsp_latency, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready, 3), "response appeared without a request three cycles earlier")

   // Reset empties the pipeline.
   `MWPO_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind multi_waveform_phase_oscillator_unit mwpo_checker u_mwpo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_sample (rsp_chan.sample)
);
